// File: hdl/sliding_window_min_max_mean_macros.svh
// Assertion helpers used by the checker file of this block.
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWMM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding window check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding window check failed");

`endif

// File: hdl/swmm_pkg.sv
`default_nettype none

package swmm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 24;
    localparam int FRAC_W   = 8;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_CALC  = 5'b01000,
        ST_WAIT  = 5'b10000
    } swmm_state_t;

    // Control from the sequencer to the statistics accumulator.
    typedef struct packed {
        logic clear;
        logic acc;
    } swmm_ctl_t;

endpackage

`default_nettype wire

// File: hdl/swmm_ring.sv
`default_nettype none

module swmm_ring
    import swmm_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [SAMPLE_W-1:0]        wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic                            rd_valid,
    output logic [SAMPLE_W-1:0]             rd_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_live_reg;
    logic                rd_valid_reg;
    logic [AW-1:0]       pos_reg;
    logic [AW-1:0]       pos_next;
    logic [CW-1:0]       fill_reg;
    logic [CW-1:0]       fill_next;

    // Writes go in order from entry zero, so every entry at or above the
    // fill count has never been written and reads as zero.
    always_comb
    begin
        pos_next  = (pos_reg == AW'(DEPTH - 1)) ? '0 : pos_reg + 1'b1;
        fill_next = (fill_reg == CW'(DEPTH)) ? fill_reg : fill_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            if (wr_en)
            begin
                pos_reg  <= pos_next;
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_live_reg <= (CW'(rd_addr) < fill_reg);
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_value = rd_live_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// File: hdl/swmm_stats.sv
`default_nettype none

module swmm_stats
    import swmm_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire swmm_ctl_t                            ctl,
    input  wire logic [SAMPLE_W-1:0]                  value,
    output logic [SAMPLE_W-1:0]                       min_val,
    output logic [SAMPLE_W-1:0]                       max_val,
    output logic [SAMPLE_W+$clog2(DEPTH)-1:0]         sum_val
);

    localparam int SUM_W = SAMPLE_W + $clog2(DEPTH);

    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SUM_W-1:0]    sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '1;
            max_reg <= '0;
            sum_reg <= '0;
        end
        else if (ctl.clear)
        begin
            min_reg <= '1;
            max_reg <= '0;
            sum_reg <= '0;
        end
        else if (ctl.acc)
        begin
            if (value < min_reg)
            begin
                min_reg <= value;
            end
            if (value > max_reg)
            begin
                max_reg <= value;
            end
            sum_reg <= sum_reg + SUM_W'(value);
        end
    end

    assign min_val = min_reg;
    assign max_val = max_reg;
    assign sum_val = sum_reg;

endmodule

`default_nettype wire

// File: hdl/swmm_scale.sv
`default_nettype none

module swmm_scale
    import swmm_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [SAMPLE_W+$clog2(DEPTH)-1:0]  sum,
    output logic                                    done,
    output logic [MEAN_W-1:0]                       mean
);

    localparam int  AW      = $clog2(DEPTH);
    localparam int  SUM_W   = SAMPLE_W + AW;
    localparam int  PW      = SUM_W + FRAC_W;
    localparam bit  IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);

    if (IS_POW2)
    begin : g_shift
        logic [MEAN_W-1:0] mean_reg;
        logic              done_reg;
        logic [PW-1:0]     scaled;

        assign scaled = {sum, {FRAC_W{1'b0}}} >> AW;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                done_reg <= 1'b0;
            end
            else if (start)
            begin
                done_reg <= 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                mean_reg <= scaled[MEAN_W-1:0];
            end
        end

        assign done = done_reg;
        assign mean = mean_reg;
    end
    else
    begin : g_divide
        // Division by the constant depth through its reciprocal. With
        // m = ceil(2^(PW+AW) / DEPTH), which has PW + 1 bits, floor(x * m / 2^(PW+AW))
        // equals floor(x / DEPTH) for every x below 2^PW. The FRAC_W zero bits of
        // x are folded into the final shift. The product is built 16 bits of m
        // per cycle, most significant chunk first. The sum input holds still
        // while this runs.
        localparam int              CH_W  = 16;
        localparam int              RW    = PW + 1;
        localparam int              NCH   = (RW + CH_W - 1) / CH_W;
        localparam int              RCW   = NCH * CH_W;
        localparam int              ACC_W = SUM_W + RCW;
        localparam int              PRD_W = SUM_W + CH_W;
        localparam int              SHIFT = SUM_W + AW;
        localparam int              NW    = $clog2(NCH + 1);
        localparam longint unsigned RECIP =
            ((64'd1 << (PW + AW)) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);

        logic [ACC_W-1:0] acc_reg;
        logic [RCW-1:0]   rcp_reg;
        logic [NW-1:0]    cnt_reg;
        logic             busy_reg;
        logic             done_reg;
        logic [PRD_W-1:0] partial;

        assign partial = PRD_W'(sum) * PRD_W'(rcp_reg[RCW-1 -: CH_W]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= NW'(NCH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                acc_reg <= '0;
                rcp_reg <= RCW'(RECIP);
            end
            else if (busy_reg)
            begin
                acc_reg <= {acc_reg[ACC_W-CH_W-1:0], {CH_W{1'b0}}} + ACC_W'(partial);
                rcp_reg <= {rcp_reg[RCW-CH_W-1:0], {CH_W{1'b0}}};
            end
        end

        assign done = done_reg;
        assign mean = acc_reg[SHIFT +: MEAN_W];
    end

endmodule

`default_nettype wire

// File: hdl/sliding_window_min_max_mean.sv
// Sliding-window minimum, maximum and mean over the last WINDOW_DEPTH samples
// (unsigned Q16.0). Each accepted sample overwrites the oldest ring entry; the
// block then walks every entry of the ring with one compare-and-add unit
// through the single read port of the sample memory, and takes no new sample
// until the item is finished. When the depth is not a power of two the mean
// is produced by multiplying with the constant reciprocal of the depth, 16
// bits of it per cycle. Entries not yet written since reset count as zero, so
// the minimum reads 0 until the ring has filled once; there is no clearing
// pass after reset. The mean is floor(sum * 256 / depth) in Q16.8. The input
// stall is high for the whole time an item is in work, and one finished
// result can wait in the output register while a new sample is taken.
`default_nettype none

module sliding_window_min_max_mean
    import swmm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_W-1:0]    sample,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [SAMPLE_W-1:0]         window_min,
    output logic [SAMPLE_W-1:0]         window_max,
    output logic [MEAN_W-1:0]           window_mean
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int SUM_W = SAMPLE_W + AW;

    swmm_state_t          state_reg;
    swmm_state_t          state_next;
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        addr_next;

    logic                 in_xfer;
    logic                 out_load;
    logic                 rd_en;
    logic                 rd_valid;
    logic [SAMPLE_W-1:0]  rd_value;
    logic [SAMPLE_W-1:0]  min_val;
    logic [SAMPLE_W-1:0]  max_val;
    logic [SUM_W-1:0]     sum_val;
    logic                 scale_start;
    logic                 scale_done;
    logic [MEAN_W-1:0]    mean_val;
    swmm_ctl_t            stats_ctl;

    logic                 out_valid_reg;
    logic [SAMPLE_W-1:0]  out_min_reg;
    logic [SAMPLE_W-1:0]  out_max_reg;
    logic [MEAN_W-1:0]    out_mean_reg;

    // New samples are taken only between items.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    // The finished result moves to the output register once that register is
    // empty or its current transfer completes in this cycle.
    assign out_load = (state_reg == ST_WAIT) && scale_done
                      && (!out_valid_reg || !out_stall);

    assign rd_en       = (state_reg == ST_SCAN);
    assign scale_start = (state_reg == ST_CALC);

    // The statistics unit is cleared as the sample is taken and then fed
    // by every ring entry as it returns from the memory.
    assign stats_ctl.clear = in_xfer;
    assign stats_ctl.acc   = rd_valid;

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_SCAN;
                    addr_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == AW'(WINDOW_DEPTH - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // The last entry is being accumulated in this cycle.
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_min_reg  <= min_val;
            out_max_reg  <= max_val;
            out_mean_reg <= mean_val;
        end
    end

    swmm_ring #(
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_xfer),
        .wr_data  (sample),
        .rd_en    (rd_en),
        .rd_addr  (addr_reg),
        .rd_valid (rd_valid),
        .rd_value (rd_value)
    );

    swmm_stats #(
        .DEPTH (WINDOW_DEPTH)
    ) u_stats (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (stats_ctl),
        .value   (rd_value),
        .min_val (min_val),
        .max_val (max_val),
        .sum_val (sum_val)
    );

    swmm_scale #(
        .DEPTH (WINDOW_DEPTH)
    ) u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .sum   (sum_val),
        .done  (scale_done),
        .mean  (mean_val)
    );

    assign out_valid   = out_valid_reg;
    assign window_min  = out_min_reg;
    assign window_max  = out_max_reg;
    assign window_mean = out_mean_reg;

endmodule

`default_nettype wire

// File: hdl/swmm_checker.sv
`default_nettype none

`include "sliding_window_min_max_mean_macros.svh"

module swmm_checker
    import swmm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [SAMPLE_W-1:0]    sample,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [SAMPLE_W-1:0]    window_min,
    input  wire logic [SAMPLE_W-1:0]    window_max,
    input  wire logic [MEAN_W-1:0]      window_mean
);

    logic                 in_xfer;
    logic [MEAN_W-1:0]    min_scaled;
    logic [MEAN_W-1:0]    max_scaled;
    logic [SAMPLE_W-1:0]  sample_seen;

    assign in_xfer     = in_valid && !in_stall;
    assign min_scaled  = {window_min, {FRAC_W{1'b0}}};
    assign max_scaled  = {window_max, {FRAC_W{1'b0}}};
    assign sample_seen = sample;

    // After a transfer the block walks the ring and cannot take another sample.
    `SWMM_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, in_stall)

    // A result offered and stalled stays offered.
    `SWMM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // Minimum and maximum come from the same set of entries.
    `SWMM_ASSERT_NOW(a_min_le_max, clk, rst_n, out_valid, window_min <= window_max)

    // The mean lies between the scaled minimum and maximum.
    `SWMM_ASSERT_NOW(a_mean_bounds, clk, rst_n, out_valid,
        (window_mean >= min_scaled) && (window_mean <= max_scaled)
            && ((sample_seen == sample) || !in_valid))

endmodule

bind sliding_window_min_max_mean swmm_checker u_swmm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .window_min  (window_min),
    .window_max  (window_max),
    .window_mean (window_mean)
);

`default_nettype wire
